// ===== src/tpr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpr_pkg - shared types and constants of the turtle plotter
// Opcodes, headings, controller states, register indexes and the command /
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tpr_pkg;

  // Command opcodes carried in the op field
  typedef enum logic [2:0] {
    OP_PEN_UP     = 3'd0,
    OP_PEN_DOWN   = 3'd1,
    OP_TURN_RIGHT = 3'd2,
    OP_TURN_LEFT  = 3'd3,
    OP_FORWARD    = 3'd4,
    OP_PRINT      = 3'd5
  } op_t;

  // Heading, clockwise from north
  typedef enum logic [1:0] {
    HEAD_NORTH = 2'd0,
    HEAD_EAST  = 2'd1,
    HEAD_SOUTH = 2'd2,
    HEAD_WEST  = 2'd3
  } heading_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_LOAD,
    ST_MARK,
    ST_PR_RD,
    ST_PR_OUT
  } state_t;

  // Configuration register indexes and widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [6:0] RESET_WIDTH  = 7'd50;
  localparam logic [4:0] RESET_HEIGHT = 5'd8;

  // Width of area dimensions (holds up to 127)
  localparam int DIM_W = 7;

  // Controller -> datapath
  typedef struct packed {
    logic accept;      // input request taken this cycle
    logic step;        // move one cell along the heading
    logic mark;        // write back the current row with the cell set
    logic print_sel;   // read port addressed by the print row
    logic print_load;  // load the output register, advance print row
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic pen_down;
    logic last_step;   // one step left
    logic steps_zero;  // no steps left
    logic out_free;    // output register empty or being drained
    logic print_last;  // current print row is the final one
  } status_t;

endpackage

// ===== src/tpr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpr_ctrl - command sequencer of the turtle plotter
// Takes one request at a time and steps the datapath through moves, row
// read-modify-write marking and the row-by-row print run.
// ----------------------------------------------------------------------------
module tpr_ctrl
  import tpr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  op_t     in_op,
  input  logic    in_steps_zero,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_op)
            OP_PEN_DOWN: state_nxt = ST_LOAD;
            OP_FORWARD:  state_nxt = in_steps_zero ? ST_IDLE : ST_STEP;
            OP_PRINT:    state_nxt = ST_PR_RD;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_STEP: begin
        if (st.pen_down) begin
          state_nxt = ST_LOAD;
        end else if (st.last_step) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_LOAD:  state_nxt = ST_MARK;
      ST_MARK:  state_nxt = st.steps_zero ? ST_IDLE : ST_STEP;
      ST_PR_RD: state_nxt = ST_PR_OUT;
      ST_PR_OUT: begin
        if (st.out_free) begin
          state_nxt = st.print_last ? ST_IDLE : ST_PR_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready       = (state_r == ST_IDLE);
    cmd.accept     = (state_r == ST_IDLE) && in_valid;
    cmd.step       = (state_r == ST_STEP);
    cmd.mark       = (state_r == ST_MARK);
    cmd.print_sel  = (state_r == ST_PR_RD) || (state_r == ST_PR_OUT);
    cmd.print_load = (state_r == ST_PR_OUT) && st.out_free;
  end

  // A step is never issued with the step count drained
  a_step_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !st.steps_zero)
    else $error("step issued with no steps left");

  // Every mark is preceded by the row read
  a_mark_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MARK) |-> $past(state_r == ST_LOAD))
    else $error("mark without preceding row read");

endmodule

// ===== src/tpr_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpr_datapath - turtle state, drawing grid and output register
// Holds pen, heading and position, the row memory with per-row valid bits,
// the step counter and print row counter, and the result register.
// ----------------------------------------------------------------------------
module tpr_datapath
  import tpr_pkg::*;
#(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output status_t          st,
  input  op_t              in_op,
  input  logic [7:0]       in_steps,
  input  logic [6:0]       width_in_use,
  input  logic [4:0]       height_in_use,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [3:0]       out_row_index,
  output logic [63:0]      out_row_bits,
  output logic             out_last
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  // Turtle state
  logic           pen_r;
  heading_t       heading_r;
  logic [CW-1:0]  col_r, col_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic [7:0]     steps_r;
  logic [RW-1:0]  pidx_r;

  // Grid memory, valid bit per row stands in for a clear
  logic [MAX_WIDTH-1:0]  mem [MAX_HEIGHT];
  logic [MAX_HEIGHT-1:0] row_vld_r;
  logic [MAX_WIDTH-1:0]  rd_data_r;
  logic                  rd_vld_r;
  logic [RW-1:0]         rd_addr;
  logic [MAX_WIDTH-1:0]  rd_row;

  // Output register
  logic        out_valid_r;
  logic [3:0]  out_idx_r;
  logic [63:0] out_bits_r;
  logic        out_last_r;

  logic [DIM_W-1:0]     eff_w, eff_h;
  logic [DIM_W-1:0]     col_ext, row_ext, pidx_ext;
  logic [MAX_WIDTH-1:0] mask;

  // Effective area: zero acts as one, oversize clamps to the maximum
  always_comb begin
    if (width_in_use == '0) begin
      eff_w = DIM_W'(1);
    end else if (width_in_use > DIM_W'(MAX_WIDTH)) begin
      eff_w = DIM_W'(MAX_WIDTH);
    end else begin
      eff_w = width_in_use;
    end
    if (height_in_use == '0) begin
      eff_h = DIM_W'(1);
    end else if (DIM_W'(height_in_use) > DIM_W'(MAX_HEIGHT)) begin
      eff_h = DIM_W'(MAX_HEIGHT);
    end else begin
      eff_h = DIM_W'(height_in_use);
    end
  end

  assign col_ext  = DIM_W'(col_r);
  assign row_ext  = DIM_W'(row_r);
  assign pidx_ext = DIM_W'(pidx_r);

  // Column mask for print
  always_comb begin
    for (int j = 0; j < MAX_WIDTH; j++) begin
      mask[j] = (DIM_W'(j) < eff_w);
    end
  end

  // One step with edge clamping
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cmd.step) begin
      unique case (heading_r)
        HEAD_NORTH: if (row_r != '0) row_nxt = row_r - RW'(1);
        HEAD_EAST:  if (col_ext + DIM_W'(1) < eff_w) col_nxt = col_r + CW'(1);
        HEAD_SOUTH: if (row_ext + DIM_W'(1) < eff_h) row_nxt = row_r + RW'(1);
        HEAD_WEST:  if (col_r != '0) col_nxt = col_r - CW'(1);
        default:    ;
      endcase
    end
  end

  // Turtle registers and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_r     <= 1'b0;
      heading_r <= HEAD_EAST;
      col_r     <= '0;
      row_r     <= '0;
      steps_r   <= '0;
      pidx_r    <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (cmd.accept) begin
        unique case (in_op)
          OP_PEN_UP:     pen_r     <= 1'b0;
          OP_PEN_DOWN:   pen_r     <= 1'b1;
          OP_TURN_RIGHT: heading_r <= heading_t'(heading_r + 2'd1);
          OP_TURN_LEFT:  heading_r <= heading_t'(heading_r - 2'd1);
          OP_FORWARD:    steps_r   <= in_steps;
          OP_PRINT:      pidx_r    <= '0;
          default:       ;
        endcase
      end else if (cmd.step) begin
        steps_r <= steps_r - 8'd1;
      end else if (cmd.print_load) begin
        pidx_r <= pidx_r + RW'(1);
      end
    end
  end

  // Row memory: one read port, one write port
  assign rd_addr = cmd.print_sel ? pidx_r : row_r;
  assign rd_row  = rd_vld_r ? rd_data_r : '0;

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    rd_vld_r  <= row_vld_r[rd_addr];
    if (cmd.mark) begin
      mem[row_r] <= rd_row | (MAX_WIDTH'(1) << col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (cmd.mark) begin
      row_vld_r[row_r] <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.print_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.print_load) begin
      out_idx_r  <= pidx_ext[3:0];
      out_bits_r <= 64'(rd_row & mask);
      out_last_r <= st.print_last;
    end
  end

  // Status
  always_comb begin
    st.pen_down   = pen_r;
    st.last_step  = (steps_r == 8'd1);
    st.steps_zero = (steps_r == 8'd0);
    st.out_free   = !out_valid_r || out_ready;
    st.print_last = (pidx_ext + DIM_W'(1) == eff_h);
  end

  assign out_valid     = out_valid_r;
  assign out_row_index = out_idx_r;
  assign out_row_bits  = out_bits_r;
  assign out_last      = out_last_r;

  // A forward run is always drained before the next request
  a_steps_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> st.steps_zero)
    else $error("request taken with steps pending");

  // A row is only loaded into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.print_load |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");

endmodule

// ===== src/turtle_plotter_raster.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// turtle_plotter_raster - turtle-graphics rasterizer over a one-bit grid
// Pen, heading and position drive marks into a row memory; print streams
// the rows in use, masked to the configured width.
// ----------------------------------------------------------------------------
// Sequencing: one request is handled at a time. Pen up, turns, unused
// opcodes and a forward of zero steps need only the request; pen down goes
// through the request, a row read, then the write back. Forward takes the
// request, then per step a move and, with the pen down, a row read and a
// write back, since each mark is a read-modify-write of one row through the
// registered read port of the grid memory. Print takes the request, then per
// row a memory read and an output register load, which waits out any stall
// on out_tready; the next request is accepted while the final row still
// waits in the output register. The grid is cleared at reset through per-row
// valid bits, so no clearing pass is needed and requests are taken right away.
// ----------------------------------------------------------------------------
module turtle_plotter_raster
  import tpr_pkg::*;
#(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // [2:0] op, [10:3] step_count, rest zero
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [71:0]           out_tdata,  // [3:0] row_index, [67:4] row_bits, rest zero
  output logic                  out_tlast,  // last_row
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [6:0]  width_r;
  logic [4:0]  height_r;
  op_t         in_op;
  logic [7:0]  in_steps;
  cmd_t        cmd;
  status_t     st;
  logic [3:0]  row_index;
  logic [63:0] row_bits;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RESET_WIDTH;
      height_r <= RESET_HEIGHT;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_WIDTH) begin
        width_r <= cfg_data;
      end else if (cfg_index == CFG_HEIGHT) begin
        height_r <= cfg_data[4:0];
      end
    end
  end

  // Request fields
  assign in_op    = op_t'(in_tdata[2:0]);
  assign in_steps = in_tdata[10:3];

  tpr_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_op         (in_op),
    .in_steps_zero (in_steps == 8'd0),
    .in_ready      (in_tready),
    .st            (st),
    .cmd           (cmd)
  );

  tpr_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .in_op         (in_op),
    .in_steps      (in_steps),
    .width_in_use  (width_r),
    .height_in_use (height_r),
    .out_ready     (out_tready),
    .out_valid     (out_tvalid),
    .out_row_index (row_index),
    .out_row_bits  (row_bits),
    .out_last      (out_tlast)
  );

  // Result packing
  assign out_tdata = {4'b0, row_bits, row_index};

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for turtle_plotter_raster
// Drives pen, turn, forward, print and unused opcodes through the command
// stream. A behavioral copy of the plotter predicts each printed row, and the
// rows that come out are checked field by field in order. The area registers
// are rewritten between phases, extremes and out-of-range values included,
// with random gaps on the command side and random stalls on the row side.
// ----------------------------------------------------------------------------
module testbench;
  import tpr_pkg::*;

  // Opcodes the block must ignore
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  // Register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
  // Idle pause; the longest command is 255 steps with the pen down
  localparam int IDLE_PAUSE = 800;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_COMMANDS = 48;

  typedef struct packed {
    logic [3:0]  row_index;
    logic [63:0] row_bits;
    logic        last_row;
  } printed_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [71:0]           out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Plotter state as the bench sees it
  logic [63:0]  grid [16];
  logic         pen_is_down;
  heading_t     turtle_heading;
  logic [5:0]   turtle_col;
  logic [3:0]   turtle_row;
  logic [6:0]   width_reg;
  logic [4:0]   height_reg;
  printed_row_t rows_due[$];

  int unsigned mismatch_count = 0;
  int unsigned burst_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  int unsigned stall_tick = 0;

  always #1 clk = ~clk;

  turtle_plotter_raster dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [2:0] op, [10:3] step_count, rest zero
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [3:0] row_index, [67:4] row_bits, rest zero
    .out_tlast  (out_tlast),  // last_row
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Effective area: zero acts as one, oversize clamps to the grid
  function automatic int unsigned area_width();
    if (width_reg == 0) return 1;
    if (width_reg > 64) return 64;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned area_height();
    if (height_reg == 0) return 1;
    if (height_reg > 16) return 16;
    return 32'(height_reg);
  endfunction

  task automatic clear_plotter();
    for (int i = 0; i < 16; i++) grid[i] = '0;
    pen_is_down    = 1'b0;
    turtle_heading = HEAD_EAST;
    turtle_col     = '0;
    turtle_row     = '0;
    width_reg      = RESET_WIDTH;
    height_reg     = RESET_HEIGHT;
  endtask

  // Apply one command to the plotter state, queue the rows a print yields
  task automatic plot_command(input logic [2:0] op, input logic [7:0] steps);
    int unsigned  w;
    int unsigned  h;
    logic [63:0]  mask;
    printed_row_t row;
    w = area_width();
    h = area_height();
    case (op)
      OP_PEN_UP: pen_is_down = 1'b0;
      OP_PEN_DOWN: begin
        pen_is_down = 1'b1;
        grid[turtle_row][turtle_col] = 1'b1;
      end
      OP_TURN_RIGHT: turtle_heading = heading_t'(turtle_heading + 2'd1);
      OP_TURN_LEFT:  turtle_heading = heading_t'(turtle_heading + 2'd3);
      OP_FORWARD: begin
        for (int s = 0; s < int'(steps); s++) begin
          // a refused step still marks the current cell
          case (turtle_heading)
            HEAD_NORTH: if (turtle_row > 0) turtle_row = turtle_row - 4'd1;
            HEAD_EAST:  if (int'(turtle_col) + 1 < w) turtle_col = turtle_col + 6'd1;
            HEAD_SOUTH: if (int'(turtle_row) + 1 < h) turtle_row = turtle_row + 4'd1;
            default:    if (turtle_col > 0) turtle_col = turtle_col - 6'd1;
          endcase
          if (pen_is_down) grid[turtle_row][turtle_col] = 1'b1;
        end
      end
      OP_PRINT: begin
        mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
        for (int i = 0; i < h; i++) begin
          row.row_index = i[3:0];
          row.row_bits  = grid[i] & mask;
          row.last_row  = (i == h - 1);
          rows_due.push_back(row);
        end
      end
      default: ;  // unused opcodes do nothing
    endcase
  endtask

  // Send one command request; the sender idles between random bursts
  task automatic send_command(input logic [2:0] op, input logic [7:0] steps);
    @(negedge clk);
    if (burst_left == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_tvalid = 1'b1;
    in_tdata  = {5'd0, steps, op};
    do @(posedge clk); while (!in_tready);
    plot_command(op, steps);
    burst_left--;
  endtask

  // Drop the request and wait until the block has nothing left to do
  task automatic wait_for_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (rows_due.size() != 0) @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_WIDTH) width_reg = data;
    else if (idx == CFG_HEIGHT) height_reg = data[4:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_area(input logic [6:0] w, input logic [6:0] h);
    wait_for_idle();
    write_register(CFG_WIDTH, w);
    write_register(CFG_HEIGHT, h);
  endtask

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch in %s: expected %h, got %h", what, want, got);
  endtask

  // Row receiver stalls in modes that change every so often
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= (stall_tick % 4 == 0);
      default: out_tready <= (stall_tick % 11 > 6);
    endcase
  end

  // Compare each printed row with the oldest one due
  always @(posedge clk) begin : check_rows
    printed_row_t due;
    if (rst_n && out_tvalid && out_tready) begin
      if (rows_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected row: index %0d bits %h", out_tdata[3:0], out_tdata[67:4]);
      end else begin
        due = rows_due.pop_front();
        if (out_tdata[3:0] !== due.row_index)
          note_mismatch("row_index", 64'(due.row_index), 64'(out_tdata[3:0]));
        if (out_tdata[67:4] !== due.row_bits)
          note_mismatch("row_bits", due.row_bits, out_tdata[67:4]);
        if (out_tlast !== due.last_row)
          note_mismatch("last_row", 64'(due.last_row), 64'(out_tlast));
        if (out_tdata[71:68] !== 4'd0)
          note_mismatch("tdata padding", 64'd0, 64'(out_tdata[71:68]));
      end
    end
  end

  // Reset area: pen, both turns with wrap, edge clamps, ignored commands
  task automatic test_pen_and_heading();
    send_command(OP_PRINT, 8'd0);
    send_command(OP_PEN_DOWN, 8'd0);
    send_command(OP_FORWARD, 8'd255);
    send_command(OP_TURN_RIGHT, 8'd0);
    send_command(OP_FORWARD, 8'd255);
    send_command(OP_TURN_RIGHT, 8'd0);
    send_command(OP_TURN_RIGHT, 8'd0);
    send_command(OP_FORWARD, 8'd2);
    send_command(OP_TURN_LEFT, 8'd0);
    send_command(OP_TURN_LEFT, 8'd0);
    send_command(OP_PEN_UP, 8'd0);
    send_command(OP_FORWARD, 8'd0);
    send_command(OP_SPARE_6, 8'd255);
    send_command(OP_SPARE_7, 8'd170);
    send_command(OP_FORWARD, 8'd1);
    send_command(OP_PRINT, 8'd85);
  endtask

  // Smallest, largest and out-of-range areas, and an area shrunk under the turtle
  task automatic test_area_limits();
    set_area(7'd1, 7'd1);
    send_command(OP_PRINT, 8'd0);
    set_area(7'd64, 7'd16);
    send_command(OP_PEN_DOWN, 8'd0);
    send_command(OP_FORWARD, 8'd255);
    send_command(OP_TURN_RIGHT, 8'd0);
    send_command(OP_FORWARD, 8'd255);
    send_command(OP_PRINT, 8'd0);
    set_area(7'd0, 7'd0);
    send_command(OP_PRINT, 8'd0);
    set_area(7'd127, 7'd127);
    send_command(OP_PRINT, 8'd0);
    set_area(7'd10, 7'd4);
    write_register(CFG_SPARE_2, 7'd127);
    write_register(CFG_SPARE_3, 7'd0);
    send_command(OP_FORWARD, 8'd3);
    send_command(OP_TURN_RIGHT, 8'd0);
    send_command(OP_FORWARD, 8'd5);
    send_command(OP_PRINT, 8'd0);
  endtask

  // Random drawing under a new area each phase
  task automatic test_random_drawing();
    logic [6:0]  w;
    logic [6:0]  h;
    logic [2:0]  op;
    logic [7:0]  steps;
    int unsigned pick;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin w = 7'd64; h = 7'd16; end
        1: begin w = 7'd1;  h = 7'd1;  end
        2: begin w = 7'd0;  h = 7'd0;  end
        3: begin w = 7'd127; h = 7'd17; end
        default: begin
          w = 7'($urandom_range(1, 64));
          h = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                          : 7'($urandom_range(1, 16));
        end
      endcase
      set_area(w, h);
      for (int n = 0; n < PHASE_COMMANDS; n++) begin
        pick  = $urandom_range(0, 99);
        steps = 8'($urandom_range(0, 255));
        if (pick < 10)      op = OP_PEN_UP;
        else if (pick < 25) op = OP_PEN_DOWN;
        else if (pick < 37) op = OP_TURN_RIGHT;
        else if (pick < 49) op = OP_TURN_LEFT;
        else if (pick < 82) begin
          op = OP_FORWARD;
          // mostly short moves to keep runs brisk
          if ($urandom_range(0, 6) != 0) steps = 8'($urandom_range(0, 20));
        end
        else if (pick < 95) op = OP_PRINT;
        else                op = (pick < 97) ? OP_SPARE_6 : OP_SPARE_7;
        send_command(op, steps);
      end
    end
  endtask

  initial begin
    clear_plotter();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_pen_and_heading();
    test_area_limits();
    test_random_drawing();
    wait_for_idle();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run limit
  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
